@@ rtl/core/rifll_pkg.sv @@
// rifll_pkg: constants and saturation helpers for the resonant integrator fll
// no dependencies
`timescale 1ns / 1ps
package rifll_pkg;
  localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd429497;
  localparam logic [31:0] RES_GAIN_RST      = 32'd92681;
  localparam logic [31:0] LOOP_GAIN_RST     = 32'd65536;
  localparam logic [31:0] NORM_GAIN_RST     = 32'd65536;
  localparam logic [31:0] CENTRE_FREQ_RST   = 32'd20588880;
  localparam logic [31:0] FREQ_RST          = 32'd823550;
  localparam logic [30:0] AMP_FLOOR         = 31'd3355443;

  typedef enum logic [2:0] {
    REG_PERIOD = 3'd0,
    REG_RES_GAIN = 3'd1,
    REG_LOOP_GAIN = 3'd2,
    REG_NORM_GAIN = 3'd3,
    REG_CENTRE = 3'd4
  } reg_idx_t;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
    if (x > 80'sd2147483647) return 32'sh7fffffff;
    else if (x < -80'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [46:0] sat47(input logic signed [79:0] x);
    if (x > 80'sd70368744177663) return {1'b0, {46{1'b1}}};
    else if (x < -80'sd70368744177664) return {1'b1, {46{1'b0}}};
    else return x[46:0];
  endfunction
endpackage

@@ rtl/core/resonant_integrator_fll.sv @@
// resonant_integrator_fll: sogi-fll step sequencer around one shared 33x33 multiplier,
// a bit-serial square root and a bit-serial divider; uses rifll_pkg
`timescale 1ns / 1ps
// One request in, one result out. Each sample is worked by a sequencer that runs every
// product through a single signed 33x33 multiplier (one product per cycle, registered),
// then a radix-2 square root and a restoring divide for the adaptation gain. Scaling a
// 47-bit value by the period takes two products, one for the upper 31 bits and one for
// the lower 16 bits of the value. A sample is accepted only in idle, and the sequencer
// returns to idle as the result is registered, so the block works on one sample at a
// time. s_tready stays low while the sequencer runs; a result still waiting in the
// output register holds the sequencer in its last step.
module resonant_integrator_fll (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [127:0] m_tdata,  // in_phase, quadrature, freq_est, amplitude(31), 0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rifll_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_E, S_D0, S_D1, S_A0, S_A1, S_A2, S_A3, S_A4,
    S_B0, S_B1, S_B2, S_B3, S_B4, S_EB0, S_EF0, S_EF1,
    S_W0, S_W1, S_W2, S_W3, S_W4, S_SQ0, S_SQ1, S_SQ2, S_SQRT,
    S_WO, S_KG0, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [31:0] period;
  logic signed [31:0] res_gain, loop_gain, norm_gain, centre;
  logic signed [31:0] alpha_prev, beta_prev, err_prev, loop_err_prev, adapt_gain_prev;
  logic signed [31:0] freq_delayed, freq_current, freq_offset_acc;
  logic signed [31:0] x, e, d, a, b, ef, wo_off, wo;
  logic signed [46:0] p;
  logic signed [79:0] acc;
  logic [63:0] sq, rem_sq, root_acc;
  logic [5:0] cnt;
  logic [30:0] vs;
  logic [63:0] dnum;
  logic [64:0] drem;
  logic [71:0] quo;
  logic [31:0] kg_mag;
  logic neg;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [65:0] prod_q;
  logic [63:0] trial;
  logic [64:0] dtrial;

  assign prod = ma * mb;
  assign s_tready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign trial = rem_sq - (root_acc | (64'd1 << {cnt[4:0], 1'b0}));
  assign dtrial = {drem[63:0], dnum[63]} - {34'd0, vs};
  assign kg_mag = (quo > 72'd2147483648) ? 32'h80000000 : quo[31:0];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_D0:  begin ma = {res_gain[31], res_gain}; mb = {err_prev[31], err_prev}; end
      S_A0:  begin ma = {freq_delayed[31], freq_delayed}; mb = {d[31], d}; end
      S_A1, S_B1, S_W1: begin ma = {{2{p[46]}}, p[46:16]}; mb = {1'b0, period}; end
      S_A2, S_B2, S_W2: begin ma = {17'd0, p[15:0]}; mb = {1'b0, period}; end
      S_B0:  begin ma = {freq_current[31], freq_current}; mb = {a[31], a}; end
      S_EB0: begin ma = {e[31], e}; mb = {b[31], b}; end
      S_EF0: begin ma = -{loop_gain[31], loop_gain}; mb = prod_q[64:32]; end
      S_W0:  begin ma = {loop_err_prev[31], loop_err_prev};
                   mb = {adapt_gain_prev[31], adapt_gain_prev}; end
      S_SQ0: begin ma = {a[31], a}; mb = {a[31], a}; end
      S_SQ1: begin ma = {b[31], b}; mb = {b[31], b}; end
      S_KG0: begin ma = {norm_gain[31], norm_gain}; mb = {wo[31], wo}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_q <= prod;
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      period <= SAMPLE_PERIOD_RST;
      res_gain <= RES_GAIN_RST;
      loop_gain <= LOOP_GAIN_RST;
      norm_gain <= NORM_GAIN_RST;
      centre <= CENTRE_FREQ_RST;
      alpha_prev <= '0; beta_prev <= '0; err_prev <= '0;
      loop_err_prev <= '0; adapt_gain_prev <= '0; freq_delayed <= '0;
      freq_current <= FREQ_RST; freq_offset_acc <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PERIOD:    period <= cfg_data;
          REG_RES_GAIN:  res_gain <= cfg_data;
          REG_LOOP_GAIN: loop_gain <= cfg_data;
          REG_NORM_GAIN: norm_gain <= cfg_data;
          REG_CENTRE:    centre <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin x <= s_tdata; state <= S_E; end
        S_E: begin
          e <= sat32(80'(x) - 80'(alpha_prev));
          state <= S_D0;
        end
        S_D0: state <= S_D1;
        S_D1: begin
          d <= sat32(80'(prod_q >>> 16) - 80'(beta_prev));
          state <= S_A0;
        end
        S_A0: state <= S_A4;
        S_A4: begin p <= sat47(80'(prod_q >>> 16)); state <= S_A1; end
        S_A1: state <= S_A2;
        S_A2: begin acc <= 80'(prod_q); state <= S_A3; end
        S_A3: begin
          a <= sat32(80'(alpha_prev) + (((acc <<< 16) + 80'(prod_q)) >>> 32));
          state <= S_B0;
        end
        S_B0: state <= S_B4;
        S_B4: begin p <= sat47(80'(prod_q >>> 16)); state <= S_B1; end
        S_B1: state <= S_B2;
        S_B2: begin acc <= 80'(prod_q); state <= S_B3; end
        S_B3: begin
          b <= sat32(80'(beta_prev) + (((acc <<< 16) + 80'(prod_q)) >>> 32));
          state <= S_EB0;
        end
        S_EB0: state <= S_EF0;
        S_EF0: state <= S_EF1;
        S_EF1: begin ef <= sat32(80'(prod_q >>> 16)); state <= S_W0; end
        S_W0: state <= S_W4;
        S_W4: begin p <= sat47(80'(prod_q >>> 16)); state <= S_W1; end
        S_W1: state <= S_W2;
        S_W2: begin acc <= 80'(prod_q); state <= S_W3; end
        S_W3: begin
          wo_off <= sat32(80'(freq_offset_acc) + (((acc <<< 16) + 80'(prod_q)) >>> 32));
          state <= S_SQ0;
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin sq <= prod_q[63:0]; state <= S_SQ2; end
        S_SQ2: begin
          rem_sq <= sq + prod_q[63:0];
          root_acc <= '0;
          cnt <= 6'd31;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (!trial[63] || rem_sq >= (root_acc | (64'd1 << {cnt[4:0], 1'b0}))) begin
            rem_sq <= trial;
            root_acc <= (root_acc >> 1) | (64'd1 << {cnt[4:0], 1'b0});
          end else root_acc <= root_acc >> 1;
          if (cnt == 6'd0) state <= S_WO;
          cnt <= cnt - 6'd1;
        end
        S_WO: begin
          if (root_acc[31]) vs <= 31'h7fffffff;
          else if (root_acc[30:0] < AMP_FLOOR) vs <= AMP_FLOOR;
          else vs <= root_acc[30:0];
          wo <= sat32(80'(centre) + 80'(wo_off));
          state <= S_KG0;
        end
        S_KG0: state <= S_FIN;
        S_FIN: begin
          neg <= prod_q[65];
          dnum <= prod_q[65] ? 64'(-prod_q) : prod_q[63:0];
          drem <= '0;
          quo <= '0;
          cnt <= 6'd0;
          acc <= 80'd71;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!dtrial[64]) begin
            drem <= dtrial;
            quo <= {quo[70:0], 1'b1};
          end else begin
            drem <= {drem[63:0], dnum[63]};
            quo <= {quo[70:0], 1'b0};
          end
          dnum <= {dnum[62:0], 1'b0};
          acc <= acc - 80'd1;
          if (acc == 80'd0) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            adapt_gain_prev <= neg ? -kg_mag : (kg_mag[31] ? 32'h7fffffff : kg_mag);
            loop_err_prev <= ef;
            freq_delayed <= wo;
            freq_current <= wo;
            freq_offset_acc <= wo_off;
            err_prev <= e;
            alpha_prev <= a;
            beta_prev <= b;
            m_tdata <= {1'b0, vs, wo, b, a};
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ test/rifll_checker.sv @@
// rifll_checker: watches the sample, result and register channels of resonant_integrator_fll,
// predicts each result and compares it field by field; uses rifll_pkg
`timescale 1ns / 1ps
module rifll_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending
);
  import rifll_pkg::*;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S47_MAX = 64'sd70368744177663;

  typedef struct packed {
    logic [31:0] in_phase;
    logic [31:0] quadrature;
    logic [31:0] freq_est;
    logic [30:0] amplitude;
  } sogi_out_t;

  sogi_out_t want_q[$];

  longint period, k1, g_loop, g_norm, w_centre;
  longint a_z, b_z, e_z, ef_z, kg_z, w_del, w_cur, w_off;

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint s32(longint x);
    return clip(x, S32_MIN, S32_MAX);
  endfunction

  // floor(clip47(p) * T / 2^32)
  function automatic longint times_period(longint p);
    longint pc, hi, lo;
    pc = clip(p, -S47_MAX - 1, S47_MAX);
    hi = period >>> 16;
    lo = period & 64'hffff;
    return (pc * hi + ((pc * lo) >>> 16)) >>> 16;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic sogi_out_t sogi_step(logic [31:0] sample);
    longint x, e, d, a, b, ef, off, wo, kg, vs, num;
    longint unsigned mag, q, r;
    logic neg;
    sogi_out_t o;
    x = longint'($signed(sample));
    e = s32(x - a_z);
    d = s32(((k1 * e_z) >>> 16) - b_z);
    a = s32(a_z + times_period((w_del * d) >>> 16));
    b = s32(b_z + times_period((w_cur * a) >>> 16));
    ef = s32(((-g_loop) * ((e * b) >>> 32)) >>> 16);
    off = s32(w_off + times_period((ef_z * kg_z) >>> 16));
    mag = root64(longint'(a * a) + longint'(b * b));
    if (mag > 64'd2147483647) mag = 64'd2147483647;
    vs = mag;
    if (vs < longint'(AMP_FLOOR)) vs = longint'(AMP_FLOOR);
    wo = s32(w_centre + off);
    num = g_norm * wo;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / vs;
    r = mag % vs;
    q = q * 256 + (r * 256) / vs;
    if (q > 64'd2147483648) q = 64'd2147483648;
    kg = neg ? -longint'(q) : s32(longint'(q));
    ef_z = ef;
    kg_z = kg;
    w_del = wo;
    w_cur = wo;
    w_off = off;
    e_z = e;
    a_z = a;
    b_z = b;
    o.in_phase = a[31:0];
    o.quadrature = b[31:0];
    o.freq_est = wo[31:0];
    o.amplitude = vs[30:0];
    return o;
  endfunction

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sogi_out_t got, want;
    if (rst) begin
      period = longint'(SAMPLE_PERIOD_RST);
      k1 = longint'($signed(RES_GAIN_RST));
      g_loop = longint'($signed(LOOP_GAIN_RST));
      g_norm = longint'($signed(NORM_GAIN_RST));
      w_centre = longint'($signed(CENTRE_FREQ_RST));
      a_z = 0; b_z = 0; e_z = 0; ef_z = 0; kg_z = 0; w_del = 0; w_off = 0;
      w_cur = longint'(FREQ_RST);
      want_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERIOD:    period = longint'({32'd0, cfg_data});
          REG_RES_GAIN:  k1 = longint'($signed(cfg_data));
          REG_LOOP_GAIN: g_loop = longint'($signed(cfg_data));
          REG_NORM_GAIN: g_norm = longint'($signed(cfg_data));
          REG_CENTRE:    w_centre = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) want_q.push_back(sogi_step(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[126:0];
        got.in_phase = m_tdata[31:0];
        got.quadrature = m_tdata[63:32];
        got.freq_est = m_tdata[95:64];
        got.amplitude = m_tdata[126:96];
        if (want_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
        end else begin
          want = want_q.pop_front();
          field_check("in_phase", want.in_phase, got.in_phase);
          field_check("quadrature", want.quadrature, got.quadrature);
          field_check("freq_est", want.freq_est, got.freq_est);
          field_check("amplitude", {1'b0, want.amplitude}, {1'b0, got.amplitude});
        end
      end
    end
    pending = want_q.size();
  end
endmodule

@@ test/resonant_integrator_fll_tb.sv @@
// resonant_integrator_fll_tb: drives samples and register writes into resonant_integrator_fll
// with random gaps and stalls; rifll_checker predicts and compares; uses rifll_pkg
`timescale 1ns / 1ps
module resonant_integrator_fll_tb;
  import rifll_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 3000000;

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [31:0]  s_tdata;
  logic         m_tvalid, m_tready;
  logic [127:0] m_tdata;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         hold_out;
  int           errors, pending;
  longint       cycles;
  real          period_s, phase;

  resonant_integrator_fll u_top (.*);

  rifll_checker u_check (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random ready with one long hold-off on request
  initial begin
    int r;
    logic held;
    held = 0;
    m_tready = 0;
    @(negedge rst);
    forever begin
      if (hold_out && !held) begin
        held = 1;
        m_tready <= 0;
        repeat (800) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_tready <= 1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end else begin
        m_tready <= 0;
        repeat (r > 94 ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  task automatic send(logic [31:0] x);
    s_tvalid <= 1;
    s_tdata <= x;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_sender();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    s_tvalid <= 0;
    repeat (r > 95 ? $urandom_range(30, 150) : $urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PERIOD) period_s = real'(val) / 4294967296.0;
  endtask

  task automatic write_all(logic [31:0] t, logic [31:0] k1, logic [31:0] g,
                           logic [31:0] kg, logic [31:0] wc);
    write_reg(REG_PERIOD, t);
    write_reg(REG_RES_GAIN, k1);
    write_reg(REG_LOOP_GAIN, g);
    write_reg(REG_NORM_GAIN, kg);
    write_reg(REG_CENTRE, wc);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // mostly grid-like sine runs with noise, some raw full-range values and near-extreme values
  task automatic random_samples(int n);
    int r, run;
    real amp, f, v;
    while (n > 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        amp = 0.05 + 2.0 * real'($urandom_range(0, 1000)) / 1000.0;
        f = 30.0 + real'($urandom_range(0, 40));
        run = $urandom_range(10, 60);
        repeat (run) begin
          v = amp * 16777216.0 * $sin(phase) + real'($urandom_range(0, 20000)) - 10000.0;
          phase = phase + 6.283185307 * f * period_s;
          send($rtoi(v));
          pause_sender();
          n--;
        end
      end else if (r < 85) begin
        send($urandom());
        pause_sender();
        n--;
      end else begin
        send($urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                  : 32'h80000000 + $urandom_range(0, 3));
        pause_sender();
        n--;
      end
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    cfg_valid = 0;
    cfg_index = REG_PERIOD;
    cfg_data = 0;
    hold_out = 0;
    phase = 0.0;
    period_s = real'(SAMPLE_PERIOD_RST) / 4294967296.0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings: extremes, zero input for the amplitude floor
    send(32'h0); send(32'h0); send(32'h7fffffff); send(32'h7fffffff);
    send(32'h80000000); send(32'h80000000); send(32'h1); send(32'hffffffff);
    send(32'h01000000); send(32'hff000000); send(32'h0); send(32'h55555555);
    send(32'haaaaaaaa); send(32'h0);
    random_samples(360);
    drain();

    // largest period and gains, most negative centre
    write_all(32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send(32'h7fffffff); send(32'h80000000); send(32'h0);
    random_samples(60);
    drain();

    // zero period, most negative gains, largest centre, unused index ignored
    write_all(32'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    write_reg(REG_NONE, 32'hdeadbeef);
    cfg_valid <= 0;
    @(posedge clk);
    send(32'h7fffffff); send(32'h80000000);
    random_samples(60);
    drain();

    // zero gains
    write_all(32'd429497, 32'h0, 32'h0, 32'h0, 32'h0);
    random_samples(50);
    drain();

    // long hold-off on the result side while samples keep coming
    write_all(SAMPLE_PERIOD_RST, RES_GAIN_RST, LOOP_GAIN_RST, NORM_GAIN_RST,
              CENTRE_FREQ_RST);
    hold_out <= 1;
    random_samples(300);
    drain();

    // random settings near nominal and across the range
    repeat (4) begin
      write_all($urandom_range(40000, 2000000), $urandom_range(0, 300000),
                $urandom_range(0, 400000), $urandom_range(0, 400000),
                $urandom_range(10000000, 30000000));
      random_samples(60);
      drain();
    end
    write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_samples(60);
    drain();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
